[src/drnc_pkg.sv]
// shared widths, types and helpers of the delta rms nearest centroid block
`timescale 1ns / 1ps

package drnc_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned SumW       = 38;
  localparam int unsigned RmsW       = 19;
  localparam int unsigned NumClasses = 3;
  localparam int unsigned ClassW     = 2;
  localparam int unsigned RemW       = RmsW + 2;
  localparam int unsigned StepW      = 5;

  typedef logic [NumClasses-1:0][RmsW-1:0] centroid_arr_t;

  // handshake between the top-level sequencer and an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [RmsW-1:0] cdist(input logic [RmsW-1:0] a,
                                            input logic [RmsW-1:0] b);
    cdist = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/drnc_sqrt.sv]
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps

module drnc_sqrt import drnc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] radicand_i,
  output unit_stat_t      stat_o,
  output logic [RmsW-1:0] root_o
);

  logic [SumW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RmsW-1:0]  root_q, root_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;

  // next partial remainder brings down two radicand bits
  assign rem_sh = {rem_q, rad_q[SumW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SumW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = RemW'(rem_sh - trial);
        root_d = {root_q[RmsW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rem_sh);
        root_d = {root_q[RmsW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(RmsW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

[src/drnc_nearest.sv]
// nearest centroid search, one centroid compared per cycle
`timescale 1ns / 1ps

module drnc_nearest import drnc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RmsW-1:0]   rms_i,
  input  centroid_arr_t     centroids_i,
  output unit_stat_t        stat_o,
  output logic [ClassW-1:0] class_o
);

  logic [RmsW-1:0]   rms_q;
  logic [RmsW-1:0]   best_q;
  logic [ClassW-1:0] idx_q;
  logic [ClassW-1:0] best_idx_q;
  logic              busy_q;
  logic              done_q;
  logic [RmsW-1:0]   diff;

  assign diff = cdist(rms_q, centroids_i[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      best_idx_q <= '0;
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        idx_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // strict less keeps the first index on a tie
        if (idx_q == '0 || diff < best_q) begin
          best_idx_q <= idx_q;
        end
        idx_q <= idx_q + 1'b1;
        if (idx_q == ClassW'(NumClasses - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rms_q <= rms_i;
    end
    if (busy_q && (idx_q == '0 || diff < best_q)) begin
      best_q <= diff;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign class_o     = best_idx_q;

endmodule

[src/delta_rms_nearest_centroid.sv]
// top level: sample accumulator, sequencer, config registers and result register
//
// Energy samples of one message come in on the in_valid_i / in_ready_o channel,
// SAMPLES_PER_MESSAGE words per message, each unsigned Q8.8. Every sample but
// the first of a message adds its squared difference to the previous sample
// into a 38-bit sum. A sample is taken in S_IDLE and then multiply-accumulated
// in S_ACC, during which in_ready_o is low.
// After the last sample of a message the sum goes through an iterative square
// root (one root bit per step) and a nearest centroid search over the
// three centroids (one compare per step). The input stays closed from the last
// sample until the result is loaded, most of that time in the square root.
// One word per message leaves on out_valid_o / out_ready_i with the rms and
// the class index, first index winning a tie.
// The result sits in an output register; the next message's samples are taken
// while it waits. If a new result is ready before the old one is taken the
// block holds it and stops taking input until the receiver takes the word.
// Centroids are written over the APB port at byte addresses 0, 4 and 8; the
// user must write them only while the block is idle; it does not enforce this.
// Reset clears centroids, sum, sample count, output valid; ready out of reset.
`timescale 1ns / 1ps

module delta_rms_nearest_centroid import drnc_pkg::*; #(
  parameter int unsigned SAMPLES_PER_MESSAGE = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] energy_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ClassW-1:0]  class_index_o,
  output logic [RmsW-1:0]    delta_rms_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW = $clog2(SAMPLES_PER_MESSAGE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SQRT,
    S_CLASS,
    S_OUT
  } state_e;

  localparam logic [1:0] RegCentroid0 = 2'd0;
  localparam logic [1:0] RegCentroid1 = 2'd1;
  localparam logic [1:0] RegCentroid2 = 2'd2;

  state_e             state_q;
  centroid_arr_t      cent_q;
  logic [SampleW-1:0] prev_q;
  logic [SampleW-1:0] delta_q;
  logic [SumW-1:0]    sum_q;
  logic [SumW-1:0]    sum_d;
  logic [CntW-1:0]    count_q;
  logic               last_q;
  logic               out_valid_q;
  logic [ClassW-1:0]  out_class_q;
  logic [RmsW-1:0]    out_rms_q;

  logic               in_fire;
  logic               cfg_wr;
  logic               sqrt_start;
  logic               near_start;
  logic               out_load;
  logic [RmsW-1:0]    root;
  logic [ClassW-1:0]  near_class;
  unit_stat_t         sqrt_stat;
  unit_stat_t         near_stat;
  logic [2*SampleW-1:0] delta_sq;
  logic [SampleW-1:0]   delta_in;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  // first word of a message contributes no delta
  assign delta_in   = (count_q == '0) ? '0 :
                      (energy_sample_i >= prev_q) ? (energy_sample_i - prev_q)
                                                  : (prev_q - energy_sample_i);
  assign delta_sq   = delta_q * delta_q;
  assign sum_d      = sum_q + SumW'(delta_sq);
  assign sqrt_start = (state_q == S_ACC) && last_q;
  assign near_start = (state_q == S_SQRT) && sqrt_stat.done;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  drnc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_d),
    .stat_o     (sqrt_stat),
    .root_o     (root)
  );

  drnc_nearest u_nearest (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (near_start),
    .rms_i       (root),
    .centroids_i (cent_q),
    .stat_o      (near_stat),
    .class_o     (near_class)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            prev_q  <= energy_sample_i;
            last_q  <= (count_q == CntW'(SAMPLES_PER_MESSAGE - 1));
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (last_q) begin
            sum_q   <= '0;
            prev_q  <= '0;
            count_q <= '0;
            state_q <= S_SQRT;
          end else begin
            sum_q   <= sum_d;
            count_q <= count_q + 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sqrt_stat.done) begin
            state_q <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (near_stat.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      delta_q <= delta_in;
    end
    if (out_load) begin
      out_class_q <= near_class;
      out_rms_q   <= root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegCentroid0: cent_q[0] <= pwdata[RmsW-1:0];
        RegCentroid1: cent_q[1] <= pwdata[RmsW-1:0];
        RegCentroid2: cent_q[2] <= pwdata[RmsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCentroid0: prdata = {{(32 - RmsW){1'b0}}, cent_q[0]};
      RegCentroid1: prdata = {{(32 - RmsW){1'b0}}, cent_q[1]};
      RegCentroid2: prdata = {{(32 - RmsW){1'b0}}, cent_q[2]};
      default:      prdata = '0;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign class_index_o = out_class_q;
  assign delta_rms_o   = out_rms_q;

  // taking a sample always drops in_ready_o while it is accumulated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && class_index_o == 2'd0 |->
      cdist(delta_rms_o, cent_q[0]) <= cdist(delta_rms_o, cent_q[1]) &&
      cdist(delta_rms_o, cent_q[0]) <= cdist(delta_rms_o, cent_q[2]))
    else $error("class 0 is not nearest");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && class_index_o == 2'd1 |->
      cdist(delta_rms_o, cent_q[1]) <  cdist(delta_rms_o, cent_q[0]) &&
      cdist(delta_rms_o, cent_q[1]) <= cdist(delta_rms_o, cent_q[2]))
    else $error("class 1 is not first nearest");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && class_index_o == 2'd2 |->
      cdist(delta_rms_o, cent_q[2]) < cdist(delta_rms_o, cent_q[0]) &&
      cdist(delta_rms_o, cent_q[2]) < cdist(delta_rms_o, cent_q[1]))
    else $error("class 2 is not first nearest");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> class_index_o != 2'd3)
    else $error("class index out of range");

  // each unit only runs in its own sequencer state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sqrt_stat.busy || state_q == S_SQRT) && (!near_stat.busy || state_q == S_CLASS))
    else $error("unit busy outside its state");

endmodule

[tb/tb_delta_rms_nearest_centroid.sv]
// testbench for the delta rms nearest centroid classifier: directed messages, then random ones
`timescale 1ns / 1ps

module tb_delta_rms_nearest_centroid;
  import drnc_pkg::*;

  localparam int unsigned SamplesPerMsg = 60;
  localparam int unsigned CentroidReg0  = 0;
  localparam int unsigned CentroidReg1  = 1;
  localparam int unsigned CentroidReg2  = 2;
  localparam int unsigned SpareReg      = 3;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned RxHoldCycles  = 1500;
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned RandomPhases  = 4;
  localparam int unsigned MsgsPerPhase  = 4;
  localparam int unsigned DirectedRows  = 13;
  localparam int unsigned MaxReported   = 10;

  typedef enum logic [2:0] {
    SHAPE_FLAT,
    SHAPE_STEP,
    SHAPE_ALT,
    SHAPE_RAMP,
    SHAPE_NOISE
  } msg_shape_e;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [RmsW-1:0]   rms;
  } rms_word_t;

  typedef struct {
    logic [RmsW-1:0]    c0;
    logic [RmsW-1:0]    c1;
    logic [RmsW-1:0]    c2;
    msg_shape_e         shape;
    logic [SampleW-1:0] a;
    logic [SampleW-1:0] b;
    bit                 typed;
    logic [ClassW-1:0]  cls;
    logic [RmsW-1:0]    rms;
  } msg_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] energy_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ClassW-1:0]  class_index_o;
  logic [RmsW-1:0]    delta_rms_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  logic [RmsW-1:0]    centroid_model [NumClasses];
  logic [SampleW-1:0] msg_prev;
  logic [SumW-1:0]    msg_sq_sum;
  int unsigned        msg_count;
  rms_word_t          rms_words_due [$];

  bit                 typed_next = 1'b0;
  rms_word_t          typed_word;
  bit                 tx_gaps_on = 1'b1;
  bit                 rx_gaps_on = 1'b1;
  bit                 rx_hold_req = 1'b0;
  int unsigned        rx_hold_left = 0;
  int unsigned        rx_wait = 0;
  int unsigned        errors = 0;
  int unsigned        samples_taken = 0;
  int unsigned        words_seen = 0;
  int unsigned        class_hits [NumClasses];
  int unsigned        stall_cycles = 0;
  msg_row_t           directed_plan [DirectedRows];

  delta_rms_nearest_centroid #(
    .SAMPLES_PER_MESSAGE(SamplesPerMsg)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .energy_sample_i(energy_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .class_index_o  (class_index_o),
    .delta_rms_o    (delta_rms_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MaxReported) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic logic [RmsW-1:0] floor_root(input logic [SumW-1:0] v);
    logic [RmsW-1:0] root;
    logic [RmsW-1:0] trial;
    root = '0;
    for (int b = RmsW - 1; b >= 0; b--) begin
      trial = root | (RmsW'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
    end
    return root;
  endfunction

  // folds one sample into the running sum; returns 1 when the message is complete
  function automatic bit absorb_sample(input logic [SampleW-1:0] s, output rms_word_t w);
    logic [SampleW-1:0] d;
    logic [RmsW-1:0]    rms;
    logic [RmsW-1:0]    gap;
    logic [RmsW-1:0]    best_gap;
    logic [ClassW-1:0]  best;
    w = '0;
    if (msg_count != 0) begin
      d = (s >= msg_prev) ? s - msg_prev : msg_prev - s;
      msg_sq_sum = msg_sq_sum + SumW'(64'(d) * 64'(d));
    end
    msg_prev = s;
    if (msg_count + 1 < SamplesPerMsg) begin
      msg_count++;
      return 1'b0;
    end
    rms = floor_root(msg_sq_sum);
    best = '0;
    best_gap = '0;
    for (int j = 0; j < NumClasses; j++) begin
      gap = (rms >= centroid_model[j]) ? rms - centroid_model[j] : centroid_model[j] - rms;
      // strict compare keeps the lowest index on a tie
      if (j == 0 || gap < best_gap) begin
        best_gap = gap;
        best = ClassW'(j);
      end
    end
    w.cls = best;
    w.rms = rms;
    msg_sq_sum = '0;
    msg_prev = '0;
    msg_count = 0;
    return 1'b1;
  endfunction

  // monitor: check words leaving, predict from samples entering
  always @(posedge clk_i) begin
    rms_word_t want;
    rms_word_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (class_index_o < NumClasses) class_hits[class_index_o]++;
        if (rms_words_due.size() == 0) begin
          report_error($sformatf("word with nothing due: class %0d rms %0d",
                                 class_index_o, delta_rms_o));
        end else begin
          want = rms_words_due.pop_front();
          if (class_index_o !== want.cls) begin
            report_error($sformatf("class_index expected %0d got %0d (rms %0d)",
                                   want.cls, class_index_o, want.rms));
          end
          if (delta_rms_o !== want.rms) begin
            report_error($sformatf("delta_rms expected %0d got %0d", want.rms, delta_rms_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        samples_taken++;
        if (absorb_sample(energy_sample_i, got)) begin
          if (typed_next) begin
            got = typed_word;
            typed_next = 1'b0;
          end
          rms_words_due.push_back(got);
        end
      end
    end
  end

  // receiver: random stalls per word, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rx_wait = rx_gaps_on ? $urandom_range(0, 8) : 0;
      end
      if (rx_hold_req) begin
        rx_hold_left = RxHoldCycles;
        rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d still due",
                 stall_cycles, rms_words_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] s);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    energy_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_message(input msg_shape_e shape, input logic [SampleW-1:0] a,
                              input logic [SampleW-1:0] b);
    logic [SampleW-1:0] s;
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    rx_gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < SamplesPerMsg; i++) begin
      case (shape)
        SHAPE_FLAT: s = a;
        SHAPE_STEP: s = (i < SamplesPerMsg / 2) ? a : b;
        SHAPE_ALT:  s = (i % 2 == 1) ? b : a;
        SHAPE_RAMP: s = a + SampleW'(i) * b;
        default:    s = a + SampleW'($urandom_range(0, b));
      endcase
      send_sample(s);
    end
  endtask

  // drop valid and wait until every word due has left and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rms_words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1) begin
      report_error($sformatf("pready expected 1 got %b", pready));
    end
    if (idx < NumClasses) centroid_model[idx] = v[RmsW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input int unsigned idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 4'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(centroid_model[idx])) begin
      report_error($sformatf("centroid_%0d read expected %0d got %0d",
                             idx, centroid_model[idx], prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_centroids(input logic [RmsW-1:0] c0, input logic [RmsW-1:0] c1,
                               input logic [RmsW-1:0] c2);
    write_reg(CentroidReg0, 32'(c0));
    write_reg(CentroidReg1, 32'(c1));
    write_reg(CentroidReg2, 32'(c2));
    // past the last register, must leave the centroids alone
    write_reg(SpareReg, $urandom);
    read_reg(CentroidReg0);
    read_reg(CentroidReg1);
    read_reg(CentroidReg2);
  endtask

  function automatic logic [RmsW-1:0] random_centroid();
    return RmsW'($urandom % (32'd1 << $urandom_range(4, RmsW)));
  endfunction

  initial begin
    logic [RmsW-1:0] c [NumClasses];
    logic [RmsW-1:0] t;
    int unsigned     k;
    for (int j = 0; j < NumClasses; j++) begin
      centroid_model[j] = '0;
      class_hits[j] = 0;
    end
    msg_prev = '0;
    msg_sq_sum = '0;
    msg_count = 0;

    // c0, c1, c2, shape, a, b, typed, class, rms
    directed_plan = '{
      '{0, 0, 0, SHAPE_FLAT, 16'h0000, 16'h0000, 1'b1, 0, 0},
      '{0, 0, 0, SHAPE_FLAT, 16'hFFFF, 16'h0000, 1'b1, 0, 0},
      '{0, 65535, 524287, SHAPE_STEP, 16'h0000, 16'hFFFF, 1'b1, 1, 65535},
      '{0, 65535, 524287, SHAPE_STEP, 16'hFFFF, 16'h0000, 1'b1, 1, 65535},
      '{10, 20, 30, SHAPE_STEP, 16'd100, 16'd115, 1'b1, 0, 15},
      '{10, 20, 30, SHAPE_STEP, 16'd100, 16'd125, 1'b1, 1, 25},
      '{10, 20, 30, SHAPE_STEP, 16'd0, 16'd1000, 1'b1, 2, 1000},
      '{300, 100, 200, SHAPE_STEP, 16'd0, 16'd100, 1'b1, 1, 100},
      '{524287, 524287, 524287, SHAPE_FLAT, 16'd1234, 16'd0, 1'b1, 0, 0},
      '{0, 0, 524287, SHAPE_ALT, 16'h0000, 16'hFFFF, 1'b0, 0, 0},
      '{524287, 0, 0, SHAPE_ALT, 16'hFFFF, 16'h0000, 1'b0, 0, 0},
      '{100000, 200000, 300000, SHAPE_RAMP, 16'd0, 16'd1110, 1'b0, 0, 0},
      '{0, 1, 2, SHAPE_STEP, 16'd5, 16'd4, 1'b1, 1, 1}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first row runs on the reset centroids
    for (int r = 0; r < DirectedRows; r++) begin
      if (r > 0) begin
        wait_idle();
        set_centroids(directed_plan[r].c0, directed_plan[r].c1, directed_plan[r].c2);
      end
      if (directed_plan[r].typed) begin
        typed_word.cls = directed_plan[r].cls;
        typed_word.rms = directed_plan[r].rms;
        typed_next = 1'b1;
      end
      send_message(directed_plan[r].shape, directed_plan[r].a, directed_plan[r].b);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      wait_idle();
      if (p == 0) begin
        c[0] = '0;
        c[1] = 19'd262143;
        c[2] = 19'd524287;
      end else begin
        for (int j = 0; j < NumClasses; j++) c[j] = random_centroid();
        // ascending as software writes them, except in the last phase
        if (p != RandomPhases - 1) begin
          for (int i = 0; i < NumClasses - 1; i++) begin
            for (int j = 0; j < NumClasses - 1 - i; j++) begin
              if (c[j] > c[j+1]) begin
                t = c[j];
                c[j] = c[j+1];
                c[j+1] = t;
              end
            end
          end
        end
      end
      set_centroids(c[0], c[1], c[2]);
      // receiver backs off long enough for the block to fill and stall its input
      if (p == 1) rx_hold_req = 1'b1;
      for (int m = 0; m < MsgsPerPhase; m++) begin
        k = $urandom_range(0, 9);
        if (k < 7) begin
          send_message(SHAPE_NOISE, SampleW'($urandom),
                       SampleW'((32'd1 << $urandom_range(0, SampleW)) - 1));
        end else if (k == 7) begin
          send_message(SHAPE_ALT, SampleW'($urandom), SampleW'($urandom));
        end else if (k == 8) begin
          send_message(SHAPE_RAMP, SampleW'($urandom), SampleW'($urandom_range(0, 1200)));
        end else begin
          send_message(SHAPE_STEP, SampleW'($urandom), SampleW'($urandom));
        end
      end
    end

    wait_idle();
    $display("covered %0d samples in %0d messages over %0d centroid settings",
             samples_taken, words_seen, DirectedRows + RandomPhases);
    $display("class hits: 0:%0d 1:%0d 2:%0d, one long receiver hold-off",
             class_hits[0], class_hits[1], class_hits[2]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
